[rtl/rqs_pkg.sv]
package rqs_pkg;

	localparam int DEPTH   = 16;
	localparam int SLOT_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 16;
	localparam int SIZE_W  = 32;
	localparam int RND_W   = 16;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;
	localparam int POL_W   = 2;
	localparam int CAP_W   = 5;
	localparam int ENTRY_W = ID_W + SIZE_W;
	localparam int DIVC_W  = $clog2(RND_W);
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// removal policies; the unused code behaves as FIFO
	localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
	localparam logic [POL_W-1:0] POL_SHORT = 2'd1;
	localparam logic [POL_W-1:0] POL_RAND  = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
	localparam logic [STAT_W-1:0] ST_TAKEN = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	// item actions
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// register indexes (paddr[2])
	localparam logic REG_POLICY   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_RDHEAD,
		S_HEAD,
		S_SCAN,
		S_PICKCAP,
		S_SWAP,
		S_DONE
	} rqs_state_t;

	typedef struct packed {
		logic idle;
		logic load_item;
		logic do_add;
		logic rej_full;
		logic rej_empty;
		logic div_init;
		logic div_step;
		logic rd_head;
		logic head_cap;
		logic pick_head;
		logic scan_issue;
		logic scan_cmp;
		logic pick_rd;
		logic pick_cap;
		logic take;
		logic publish;
	} rqs_cmd_t;

	typedef struct packed {
		logic             is_take;
		logic             full;
		logic             empty;
		logic             one_entry;
		logic [POL_W-1:0] policy;
		logic             div_last;
		logic             scan_more;
		logic             out_free;
	} rqs_stat_t;

endpackage

[rtl/rqs_if.sv]
interface rqs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [rqs_pkg::ID_W-1:0]    request_id;
	logic [rqs_pkg::SIZE_W-1:0]  request_size;
	logic [rqs_pkg::RND_W-1:0]   random_value;

	modport source (output valid, action, request_id, request_size, random_value,
		input ready);
	modport sink (input valid, action, request_id, request_size, random_value,
		output ready);
endinterface

interface rqs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rqs_pkg::STAT_W-1:0]  status;
	logic [rqs_pkg::ID_W-1:0]    out_request_id;
	logic [rqs_pkg::SIZE_W-1:0]  out_request_size;
	logic [rqs_pkg::OCC_W-1:0]   occupancy;

	modport source (output valid, status, out_request_id, out_request_size, occupancy,
		input ready);
	modport sink (input valid, status, out_request_id, out_request_size, occupancy,
		output ready);
endinterface

[rtl/rqs_ram.sv]
module rqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rqs_ctrl.sv]
module rqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rqs_pkg::rqs_stat_t stat,
	output rqs_pkg::rqs_cmd_t  cmd
);
	import rqs_pkg::*;

	rqs_state_t state_q, state_d;
	logic       pol_short, pol_rand;

	assign pol_short = (stat.policy == POL_SHORT);
	assign pol_rand  = (stat.policy == POL_RAND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!stat.is_take || stat.empty) state_d = S_DONE;
				else if (pol_rand)               state_d = S_DIV;
				else                             state_d = S_RDHEAD;
			end
			S_DIV: begin
				if (stat.div_last) state_d = S_RDHEAD;
			end
			S_RDHEAD: state_d = S_HEAD;
			S_HEAD: begin
				if (pol_short && !stat.one_entry) state_d = S_SCAN;
				else if (pol_rand)                state_d = S_PICKCAP;
				else                              state_d = S_SWAP;
			end
			S_SCAN: begin
				if (!stat.scan_more) state_d = S_SWAP;
			end
			S_PICKCAP: state_d = S_SWAP;
			S_SWAP:    state_d = S_DONE;
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.idle      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_EXEC: begin
				cmd.do_add    = !stat.is_take && !stat.full;
				cmd.rej_full  = !stat.is_take && stat.full;
				cmd.rej_empty = stat.is_take && stat.empty;
				cmd.div_init  = stat.is_take && !stat.empty && pol_rand;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_RDHEAD: cmd.rd_head  = 1'b1;
			S_HEAD: begin
				cmd.head_cap   = 1'b1;
				cmd.pick_head  = !pol_rand;
				cmd.scan_issue = pol_short && !stat.one_entry;
				cmd.pick_rd    = pol_rand;
			end
			S_SCAN: begin
				cmd.scan_cmp   = 1'b1;
				cmd.scan_issue = stat.scan_more;
			end
			S_PICKCAP: cmd.pick_cap = 1'b1;
			S_SWAP:    cmd.take     = 1'b1;
			S_DONE:    cmd.publish  = stat.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

[rtl/rqs_dp.sv]
module rqs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rqs_pkg::rqs_cmd_t            cmd,
	output rqs_pkg::rqs_stat_t           stat,
	input  logic                         clear_ring,
	input  logic [rqs_pkg::POL_W-1:0]    policy,
	input  logic [rqs_pkg::CAP_W-1:0]    capacity,
	input  logic                         action,
	input  logic [rqs_pkg::ID_W-1:0]     request_id,
	input  logic [rqs_pkg::SIZE_W-1:0]   request_size,
	input  logic [rqs_pkg::RND_W-1:0]    random_value,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [rqs_pkg::STAT_W-1:0]   status,
	output logic [rqs_pkg::ID_W-1:0]     out_request_id,
	output logic [rqs_pkg::SIZE_W-1:0]   out_request_size,
	output logic [rqs_pkg::OCC_W-1:0]    occupancy
);
	import rqs_pkg::*;

	// ring pointers
	logic [SLOT_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_eff;

	// latched item
	logic              act_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic [RND_W-1:0]  rnd_q;

	// remainder unit
	logic [CNT_W-1:0]  rem_q, rem_shift;
	logic [DIVC_W-1:0] divc_q;

	// scan / pick
	logic [SLOT_W-1:0] sl_q, cmp_slot_q, pick_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ID_W-1:0]   hd_id_q, best_id_q;
	logic [SIZE_W-1:0] hd_size_q, best_size_q;
	logic [CNT_W-1:0]  rand_sum;
	logic [SLOT_W-1:0] rand_pick;

	// result and output register
	logic [STAT_W-1:0] res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [SIZE_W-1:0] res_size_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [OCC_W-1:0]  out_occ_q;

	// memory port
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [ID_W-1:0]    rd_id;
	logic [SIZE_W-1:0]  rd_size;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
		input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] n;
		n = CNT_W'(s) + CNT_W'(1);
		return (n == c) ? '0 : n[SLOT_W-1:0];
	endfunction

	always_comb begin
		if (capacity == '0)                   cap_eff = CNT_W'(1);
		else if (CNT_W'(capacity) > CNT_W'(DEPTH)) cap_eff = CNT_W'(DEPTH);
		else                                  cap_eff = CNT_W'(capacity);
	end

	assign rd_id   = ram_rdata[ENTRY_W-1:SIZE_W];
	assign rd_size = ram_rdata[SIZE_W-1:0];

	assign rem_shift = {rem_q[CNT_W-2:0], rnd_q[RND_W-1]};
	assign rand_sum  = CNT_W'(head_q) + rem_q;
	assign rand_pick = (rand_sum >= cap_eff) ? SLOT_W'(rand_sum - cap_eff)
		: rand_sum[SLOT_W-1:0];

	always_comb begin
		stat.is_take   = (act_q == ACT_TAKE);
		stat.full      = (count_q >= cap_eff);
		stat.empty     = (count_q == '0);
		stat.one_entry = (count_q == CNT_W'(1));
		stat.policy    = policy;
		stat.div_last  = (divc_q == DIVC_W'(RND_W - 1));
		stat.scan_more = (idx_q < count_q);
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {id_q, size_q};
		if (cmd.do_add) begin
			ram_we = 1'b1;
		end else if (cmd.take) begin
			// head entry moves into the vacated slot
			ram_we    = 1'b1;
			ram_waddr = pick_q;
			ram_wdata = {hd_id_q, hd_size_q};
		end
	end

	always_comb begin
		ram_raddr = head_q;
		if (cmd.scan_issue)   ram_raddr = sl_q;
		else if (cmd.pick_rd) ram_raddr = pick_q;
	end

	rqs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear_ring) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.do_add) begin
				tail_q  <= slot_inc(tail_q, cap_eff);
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.take) begin
				head_q  <= slot_inc(head_q, cap_eff);
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.publish)    out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q  <= action;
			id_q   <= request_id;
			size_q <= request_size;
			rnd_q  <= random_value;
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			divc_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= (rem_shift >= count_q) ? rem_shift - count_q : rem_shift;
			rnd_q  <= {rnd_q[RND_W-2:0], 1'b0};
			divc_q <= divc_q + DIVC_W'(1);
		end
		if (cmd.rd_head) begin
			sl_q   <= slot_inc(head_q, cap_eff);
			idx_q  <= CNT_W'(1);
			pick_q <= rand_pick;
		end
		if (cmd.head_cap) begin
			hd_id_q     <= rd_id;
			hd_size_q   <= rd_size;
			best_id_q   <= rd_id;
			best_size_q <= rd_size;
			if (cmd.pick_head) pick_q <= head_q;
		end
		if (cmd.scan_cmp && (rd_size < best_size_q)) begin
			best_id_q   <= rd_id;
			best_size_q <= rd_size;
			pick_q      <= cmp_slot_q;
		end
		if (cmd.scan_issue) begin
			cmp_slot_q <= sl_q;
			sl_q       <= slot_inc(sl_q, cap_eff);
			idx_q      <= idx_q + CNT_W'(1);
		end
		if (cmd.pick_cap) begin
			best_id_q   <= rd_id;
			best_size_q <= rd_size;
		end
		if (cmd.do_add || cmd.rej_full || cmd.rej_empty) begin
			res_id_q   <= '0;
			res_size_q <= '0;
			res_status_q <= cmd.do_add ? ST_ADDED : (cmd.rej_full ? ST_FULL : ST_EMPTY);
		end else if (cmd.take) begin
			res_status_q <= ST_TAKEN;
			res_id_q     <= best_id_q;
			res_size_q   <= best_size_q;
		end
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_size_q   <= res_size_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign out_request_id   = out_id_q;
	assign out_request_size = out_size_q;
	assign occupancy        = out_occ_q;

endmodule

[rtl/request_queue_scheduler.sv]
// Request queue scheduler: a ring of up to 16 (id, size) request entries
// held in a single-port-write, single-port-read RAM. Each transaction on
// req_in either adds a request at the tail (action 0) or takes one (action
// 1) under the policy register: FIFO takes the head, shortest-first scans
// the occupied slots from the head and takes the first smallest size,
// random takes the slot at head + (random_value mod count) and moves the
// head entry into it. Every transaction yields exactly one rsp_out
// transaction with status, taken id/size (zero unless taken) and the
// occupancy afterwards. Adds to a full ring and takes from an empty one
// are rejected with no state change. Items are processed one at a time:
// a shortest-first take does one RAM read per occupied slot, pipelined
// behind the registered read port, and a random take waits while the
// remainder unit retires one bit of random_value per cycle. The next
// item is accepted in the cycle after the result moves into the output
// register, even while that register still waits on rsp_out.ready.
// Registers sit on
// an APB port: policy at 0x0, capacity at 0x4 (0 acts as 1, above 16 acts
// as 16). Any capacity write empties the ring; write it only while idle.
module request_queue_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	rqs_req_if.sink                     req_in,
	rqs_rsp_if.source                   rsp_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rqs_pkg::APB_AW-1:0]  paddr,
	input  logic [rqs_pkg::APB_DW-1:0]  pwdata,
	output logic [rqs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import rqs_pkg::*;

	logic [POL_W-1:0] policy_q;
	logic [CAP_W-1:0] capacity_q;
	logic             cfg_wr;
	logic             cap_wr;
	rqs_cmd_t         cmd;
	rqs_stat_t        stat;

	// APB: zero-wait writes in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cap_wr = cfg_wr && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= POL_FIFO;
			capacity_q <= CAP_W'(DEPTH);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_POLICY) policy_q   <= pwdata[POL_W-1:0];
			else                        capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_POLICY) prdata = APB_DW'(policy_q);
		else                        prdata = APB_DW'(capacity_q);
	end

	// input handshake: one item in flight
	assign req_in.ready = cmd.idle;

	rqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_in.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	rqs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.clear_ring       (cap_wr),
		.policy           (policy_q),
		.capacity         (capacity_q),
		.action           (req_in.action),
		.request_id       (req_in.request_id),
		.request_size     (req_in.request_size),
		.random_value     (req_in.random_value),
		.out_ready        (rsp_out.ready),
		.out_valid        (rsp_out.valid),
		.status           (rsp_out.status),
		.out_request_id   (rsp_out.out_request_id),
		.out_request_size (rsp_out.out_request_size),
		.occupancy        (rsp_out.occupancy)
	);

endmodule
